>>> sv/levenshtein_edit_distance_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edit distance block.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LEVENSHTEIN_EDIT_DISTANCE_ASSERT_SVH
`define LEVENSHTEIN_EDIT_DISTANCE_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define LED_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define LED_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/led_pkg.sv
// ----------------------------------------------------------------------------
// led_pkg
// Shared types and codes of the edit distance block: transaction payloads,
// action codes and the control group that travels along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package led_pkg;

	localparam int unsigned SYM_W  = 8;
	localparam int unsigned DIST_W = 7;

	localparam logic [1:0] ACT_FIRST  = 2'd0;
	localparam logic [1:0] ACT_SECOND = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [SYM_W-1:0] symbol;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} rsp_t;

	// Control group handed from one cell to the next every cycle.
	typedef struct packed {
		logic             chr_vld;
		logic             tok;
		logic             ovf;
		logic [SYM_W-1:0] chr;
	} ctl_t;

endpackage

`default_nettype wire

>>> sv/led_head.sv
// ----------------------------------------------------------------------------
// led_head
// Front of the cell row: keeps both word lengths and the overflow flag,
// steers first-word characters into their cells and launches second-word
// characters and the finish token into the row.
// ----------------------------------------------------------------------------
`default_nettype none

module led_head #(
	parameter int unsigned MAX_LEN = 64,
	parameter int unsigned W       = 7
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         take,
	input  wire led_pkg::req_t          req,
	output logic [MAX_LEN-1:0]          load_we,
	output logic [led_pkg::SYM_W-1:0]   load_sym,
	output led_pkg::ctl_t               next_ctl,
	output logic [W-1:0]                next_newv,
	output logic [W-1:0]                next_diag,
	output logic [W-1:0]                next_dist
);
	import led_pkg::*;

	localparam logic [W-1:0] LEN_MAX = W'(MAX_LEN);

	logic [W-1:0]       first_len_q;
	logic [W-1:0]       sec_len_q;
	logic               ovf_q;
	logic [MAX_LEN-1:0] we_d;
	logic               do_load;
	logic               do_char;

	// One-hot select of the cell that takes the next first-word character.
	always_comb begin
		for (int k = 0; k < MAX_LEN; k++) begin
			we_d[k] = (first_len_q == W'(k));
		end
	end

	assign do_load = take && (req.action == ACT_FIRST) && (sec_len_q == '0)
		&& (first_len_q != LEN_MAX);
	assign do_char = take && (req.action == ACT_SECOND) && (sec_len_q != LEN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q <= '0;
			sec_len_q   <= '0;
			ovf_q       <= 1'b0;
			load_we     <= '0;
			next_ctl    <= '0;
		end else begin
			load_we          <= do_load ? we_d : '0;
			next_ctl.chr_vld <= do_char;
			next_ctl.tok     <= take && (req.action == ACT_FINISH);
			if (take) begin
				case (req.action)
					ACT_FIRST: begin
						if (sec_len_q == '0) begin
							if (first_len_q == LEN_MAX) begin
								ovf_q <= 1'b1;
							end else begin
								first_len_q <= first_len_q + W'(1);
							end
						end
					end
					ACT_SECOND: begin
						if (sec_len_q == LEN_MAX) begin
							ovf_q <= 1'b1;
						end else begin
							next_ctl.chr <= req.symbol;
							sec_len_q    <= sec_len_q + W'(1);
						end
					end
					ACT_FINISH: begin
						// The token clears each cell as it passes.
						next_ctl.ovf <= ovf_q;
						first_len_q  <= '0;
						sec_len_q    <= '0;
						ovf_q        <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			load_sym <= req.symbol;
		end
		if (do_char) begin
			next_newv <= sec_len_q + W'(1);
			next_diag <= sec_len_q;
		end
		if (take && (req.action == ACT_FINISH)) begin
			next_dist <= sec_len_q;
		end
	end

endmodule

`default_nettype wire

>>> sv/led_cell.sv
// ----------------------------------------------------------------------------
// led_cell
// One column of the distance row: holds one first-word character and its row
// entry, updates the entry for each passing second-word character and hands
// the new and old entries to its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module led_cell #(
	parameter int unsigned W   = 7,
	parameter int unsigned IDX = 1
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         load_we,
	input  wire [led_pkg::SYM_W-1:0]    load_sym,
	input  wire led_pkg::ctl_t          prev_ctl,
	input  wire [W-1:0]                 prev_newv,
	input  wire [W-1:0]                 prev_diag,
	input  wire [W-1:0]                 prev_dist,
	output led_pkg::ctl_t               next_ctl,
	output logic [W-1:0]                next_newv,
	output logic [W-1:0]                next_diag,
	output logic [W-1:0]                next_dist
);
	import led_pkg::*;

	localparam logic [W-1:0] D_RST = W'(IDX);

	logic [SYM_W-1:0] chr_q;
	logic             used_q;
	logic [W-1:0]     d_q;
	logic [W:0]       via_above;
	logic [W:0]       via_left;
	logic [W:0]       via_diag;
	logic [W:0]       best;
	logic [W-1:0]     best_w;

	assign via_above = {1'b0, d_q} + (W+1)'(1);
	assign via_left  = {1'b0, prev_newv} + (W+1)'(1);
	assign via_diag  = {1'b0, prev_diag} + (W+1)'(chr_q != prev_ctl.chr);

	always_comb begin
		best = (via_above < via_left) ? via_above : via_left;
		if (via_diag < best) begin
			best = via_diag;
		end
	end

	// A row entry never exceeds the longest word, so the top bit is zero.
	assign best_w = best[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			d_q      <= D_RST;
			next_ctl <= '0;
		end else begin
			next_ctl <= prev_ctl;
			if (prev_ctl.tok) begin
				used_q <= 1'b0;
				d_q    <= D_RST;
			end else begin
				if (load_we) begin
					used_q <= 1'b1;
				end
				if (prev_ctl.chr_vld && used_q) begin
					d_q <= best_w;
				end
			end
		end
	end

	// Unused cells pass their neighbor's values through; the last used cell
	// therefore leaves its own entry on the distance lane.
	always_ff @(posedge clk) begin
		if (load_we) begin
			chr_q <= load_sym;
		end
		next_newv <= used_q ? best_w : prev_newv;
		next_diag <= used_q ? d_q : prev_diag;
		next_dist <= used_q ? d_q : prev_dist;
	end

endmodule

`default_nettype wire

>>> sv/levenshtein_edit_distance.sv
// ----------------------------------------------------------------------------
// levenshtein_edit_distance
// Unit-cost edit distance between two byte strings on a systolic cell row.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req (action, symbol) with req_valid/req_stall; results
// leave on rsp (distance, overflow) with rsp_valid/rsp_stall.
// Load the first word with one append-first transaction per character, then
// stream the second word, one append-second transaction per character; each
// of these may follow back to back while req_stall is low. A character is dropped and
// overflow set once a word would exceed MAX_LEN characters.
// A finish transaction sends a token down the MAX_LEN cells behind the last
// character; the result is registered at the output once the token has passed
// the head and every cell of the row. While the token travels, req_stall is
// high; a finish is also held while an earlier result is still waiting,
// other requests are not. The token clears the row, so the block is ready for
// the next word pair when the result appears.
// Reset clears both words, the lengths and the overflow flag at once. A
// stalled result stays in its output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module levenshtein_edit_distance #(
	parameter int unsigned MAX_LEN = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  wire led_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output led_pkg::rsp_t        rsp
);
	import led_pkg::*;

	`include "levenshtein_edit_distance_assert.svh"

	localparam int unsigned W = $clog2(MAX_LEN + 1);

	logic               take;
	logic               fin_take;
	logic               tok_out;
	logic               drain_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic [MAX_LEN-1:0] load_we;
	logic [SYM_W-1:0]   load_sym;
	ctl_t               lane_ctl  [0:MAX_LEN];
	logic [W-1:0]       lane_newv [0:MAX_LEN];
	logic [W-1:0]       lane_diag [0:MAX_LEN];
	logic [W-1:0]       lane_dist [0:MAX_LEN];

	assign req_stall = drain_q || ((req.action == ACT_FINISH) && rsp_valid_q);
	assign take      = req_valid && !req_stall;
	assign fin_take  = take && (req.action == ACT_FINISH);
	assign tok_out   = lane_ctl[MAX_LEN].tok;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	led_head #(
		.MAX_LEN (MAX_LEN),
		.W       (W)
	) u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req       (req),
		.load_we   (load_we),
		.load_sym  (load_sym),
		.next_ctl  (lane_ctl[0]),
		.next_newv (lane_newv[0]),
		.next_diag (lane_diag[0]),
		.next_dist (lane_dist[0])
	);

	for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
		led_cell #(
			.W   (W),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load_we   (load_we[i-1]),
			.load_sym  (load_sym),
			.prev_ctl  (lane_ctl[i-1]),
			.prev_newv (lane_newv[i-1]),
			.prev_diag (lane_diag[i-1]),
			.prev_dist (lane_dist[i-1]),
			.next_ctl  (lane_ctl[i]),
			.next_newv (lane_newv[i]),
			.next_diag (lane_diag[i]),
			.next_dist (lane_dist[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin_take) begin
				drain_q <= 1'b1;
			end else if (tok_out) begin
				drain_q <= 1'b0;
			end
			// The output register is always empty when the token arrives.
			if (tok_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_out) begin
			rsp_q.overflow <= lane_ctl[MAX_LEN].ovf;
			rsp_q.distance <= lane_ctl[MAX_LEN].ovf ? '0 : DIST_W'(lane_dist[MAX_LEN]);
		end
	end

	`LED_ASSERT_NEVER(a_tok_full, clk, arst_n, tok_out && rsp_valid_q, "token met a full output")
	`LED_ASSERT(a_fin_drain, clk, arst_n, fin_take |=> drain_q, "finish did not start the drain")
	`LED_ASSERT(a_rsp_src, clk, arst_n, $rose(rsp_valid_q) |-> $past(tok_out), "result without a token")
	`LED_ASSERT_NEVER(a_drain_chr, clk, arst_n, drain_q && lane_ctl[0].chr_vld, "character in drain")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: edit distance block testbench
// Drives word pairs into the block and checks every distance it reports.
// A short scripted opening covers reset, empty words, ignored actions and
// extreme bytes. Random word pairs follow, some of them long enough to
// overflow. A behavioral copy of the dynamic-programming row predicts each
// result. Both channels pause at random except in the closing stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import led_pkg::*;

	localparam int unsigned MAX_LEN    = 64;
	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam int          ITEM_GOAL  = 900;
	localparam int          QUIET_FROM = 780;

	typedef struct packed {
		logic [1:0]        action;
		logic [SYM_W-1:0]  symbol;
		logic              typed;
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} script_row_t;

	localparam int SCRIPT_LEN = 20;

	// Rows with typed set carry a hand-computed result for their finish.
	localparam script_row_t OPENING [SCRIPT_LEN] = '{
		'{ACT_FINISH, 8'h00, 1'b1, 7'd0, 1'b0},
		'{ACT_UNUSED, 8'hFF, 1'b0, 7'd0, 1'b0},
		'{ACT_FIRST,  8'h00, 1'b0, 7'd0, 1'b0},
		'{ACT_FINISH, 8'hFF, 1'b1, 7'd1, 1'b0},
		'{ACT_SECOND, 8'hFF, 1'b0, 7'd0, 1'b0},
		'{ACT_SECOND, 8'hAA, 1'b0, 7'd0, 1'b0},
		'{ACT_FINISH, 8'h00, 1'b1, 7'd2, 1'b0},
		'{ACT_FIRST,  8'h61, 1'b0, 7'd0, 1'b0},
		'{ACT_FIRST,  8'h62, 1'b0, 7'd0, 1'b0},
		'{ACT_SECOND, 8'h62, 1'b0, 7'd0, 1'b0},
		'{ACT_FIRST,  8'h78, 1'b0, 7'd0, 1'b0},
		'{ACT_SECOND, 8'h61, 1'b0, 7'd0, 1'b0},
		'{ACT_FINISH, 8'h55, 1'b1, 7'd2, 1'b0},
		'{ACT_FIRST,  8'hFF, 1'b0, 7'd0, 1'b0},
		'{ACT_SECOND, 8'hFF, 1'b0, 7'd0, 1'b0},
		'{ACT_UNUSED, 8'h00, 1'b0, 7'd0, 1'b0},
		'{ACT_FINISH, 8'hAA, 1'b1, 7'd0, 1'b0},
		'{ACT_FIRST,  8'h55, 1'b0, 7'd0, 1'b0},
		'{ACT_SECOND, 8'h5A, 1'b0, 7'd0, 1'b0},
		'{ACT_FINISH, 8'h00, 1'b1, 7'd1, 1'b0}
	};

	logic  clk = 1'b0;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	levenshtein_edit_distance #(.MAX_LEN(MAX_LEN)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Predicted block state.
	logic [SYM_W-1:0] first_word [MAX_LEN];
	int unsigned      first_len;
	int unsigned      second_len;
	int unsigned      dist_row [MAX_LEN+1];
	bit               too_long;

	rsp_t pending_distances [$];
	int   mismatches;
	int   real_items;
	bit   quiet;
	bit   calm;
	int   calm_left;
	int   stall_left;
	bit   cur_typed;
	rsp_t cur_want;

	function automatic void clear_words();
		first_len  = 0;
		second_len = 0;
		too_long   = 1'b0;
		for (int i = 0; i <= MAX_LEN; i++)
			dist_row[i] = i;
	endfunction

	function automatic void fold_second_char(input logic [SYM_W-1:0] ch);
		int unsigned diag;
		int unsigned above;
		int unsigned best;
		diag = dist_row[0];
		second_len++;
		dist_row[0] = second_len;
		for (int unsigned i = 1; i <= first_len; i++) begin
			above = dist_row[i];
			best = (above + 1 < dist_row[i-1] + 1) ? above + 1 : dist_row[i-1] + 1;
			if (diag + (first_word[i-1] != ch) < best)
				best = diag + (first_word[i-1] != ch);
			diag = above;
			dist_row[i] = best;
		end
	endfunction

	// Updates the predicted state for one transaction; a finish yields a result.
	function automatic bit predict_distance(input req_t item, output rsp_t res);
		res = '0;
		case (item.action)
			ACT_FIRST: begin
				if (second_len == 0) begin
					if (first_len >= MAX_LEN) begin
						too_long = 1'b1;
					end else begin
						first_word[first_len] = item.symbol;
						first_len++;
					end
				end
			end
			ACT_SECOND: begin
				if (second_len >= MAX_LEN)
					too_long = 1'b1;
				else
					fold_second_char(item.symbol);
			end
			ACT_FINISH: begin
				res.overflow = too_long;
				res.distance = too_long ? '0 : DIST_W'(dist_row[first_len]);
				clear_words();
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send(input logic [1:0] action, input logic [SYM_W-1:0] symbol,
			input bit typed, input rsp_t want);
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_valid = 1'b1;
		req.action = action;
		req.symbol = symbol;
		cur_typed = typed;
		cur_want = want;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol(input int mode, input logic [SYM_W-1:0] base,
			input bit second);
		case (mode)
			0: return base + SYM_W'($urandom_range(0, 2));
			1: return SYM_W'($urandom_range(0, 255));
			default: return {second, 7'($urandom_range(0, 127))};
		endcase
	endfunction

	// One word pair followed by a finish; noise items are ignored by the block.
	task automatic send_pair(input int la, input int lb, input int mode);
		logic [SYM_W-1:0] base;
		base = SYM_W'($urandom_range(0, 255));
		for (int i = 0; i < la; i++) begin
			if ($urandom_range(0, 24) == 0)
				send(ACT_UNUSED, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
			send(ACT_FIRST, pick_symbol(mode, base, 1'b0), 1'b0, '0);
		end
		for (int i = 0; i < lb; i++) begin
			if (i > 0 && $urandom_range(0, 19) == 0)
				send(ACT_FIRST, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
			send(ACT_SECOND, pick_symbol(mode, base, 1'b1), 1'b0, '0);
		end
		send(ACT_FINISH, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
		real_items += la + lb + 1;
		if (real_items >= QUIET_FROM)
			quiet = 1'b1;
	endtask

	// Compare completed results against the oldest prediction, then predict.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t guess;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_distances.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: distance %0d overflow %0d",
							rsp.distance, rsp.overflow);
				end else begin
					want = pending_distances.pop_front();
					if (rsp.distance !== want.distance || rsp.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected distance %0d overflow %0d, ",
								want.distance, want.overflow,
								"got distance %0d overflow %0d",
								rsp.distance, rsp.overflow);
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (predict_distance(req, guess))
					pending_distances.insert(pending_distances.size(),
						cur_typed ? cur_want : guess);
			end
		end
	end

	// Result-side back pressure in short bursts, with calm stretches.
	always @(negedge clk) begin
		if (calm_left == 0) begin
			calm <= ~calm;
			calm_left <= $urandom_range(20, 200);
		end else begin
			calm_left <= calm_left - 1;
		end
		if (quiet || calm || !arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		rsp_t want;
		int   pick;
		int   la;
		int   lb;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		quiet = 1'b0;
		calm = 1'b0;
		calm_left = 50;
		stall_left = 0;
		mismatches = 0;
		real_items = 0;
		cur_typed = 1'b0;
		cur_want = '0;
		clear_words();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < SCRIPT_LEN; r++) begin
			want.distance = OPENING[r].distance;
			want.overflow = OPENING[r].overflow;
			send(OPENING[r].action, OPENING[r].symbol, OPENING[r].typed, want);
		end

		// Longest words with disjoint alphabets, then each word overflowing.
		send_pair(MAX_LEN, MAX_LEN, 2);
		send_pair(MAX_LEN + 1, 3, 1);
		send_pair(2, MAX_LEN + 1, 1);
		while (real_items < ITEM_GOAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				la = $urandom_range(MAX_LEN - 2, MAX_LEN + 2);
				lb = $urandom_range(0, 1) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 2)
					: $urandom_range(0, 4);
				send_pair(la, lb, $urandom_range(1, 2));
			end else begin
				send_pair($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 1));
			end
		end
		req_valid = 1'b0;

		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (MAX_LEN + 8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
